// File: hdl/lr_pkg.sv
`timescale 1ns / 1ps
package lr_pkg;

  localparam logic       MODE_START   = 1'b0;
  localparam logic       MODE_ADVANCE = 1'b1;
  localparam logic [31:0] COLOR_RESET = 32'h90FF_FFC8;

  typedef struct packed {
    logic               mode;
    logic signed [11:0] start_x;
    logic signed [11:0] start_y;
    logic signed [11:0] end_x;
    logic signed [11:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] pixel_x;
    logic signed [11:0] pixel_y;
    logic               on_screen;
    logic [19:0]        pixel_address;
    logic [31:0]        pixel_color;
    logic               last_pixel;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic               mode;
    logic signed [11:0] x0;
    logic signed [11:0] y0;
    logic signed [11:0] x1;
    logic signed [11:0] y1;
    logic [12:0]        delta_x;
    logic signed [13:0] neg_delta_y;
    logic               step_x_neg;
    logic               step_y_neg;
    logic signed [14:0] error_term;
  } cmd_t;

endpackage

// File: hdl/lr_fifo.sv
`timescale 1ns / 1ps
module lr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// File: hdl/lr_front.sv
`timescale 1ns / 1ps
module lr_front (
  input  lr_pkg::in_item_t item,
  output lr_pkg::cmd_t     cmd
);
  import lr_pkg::*;

  logic signed [12:0] diff_x;
  logic signed [12:0] diff_y;
  logic signed [12:0] abs_x;
  logic signed [12:0] nabs_y;

  always_comb begin
    diff_x = 13'(item.end_x) - 13'(item.start_x);
    diff_y = 13'(item.end_y) - 13'(item.start_y);
    abs_x  = (diff_x > 13'sd0) ? diff_x : -diff_x;
    nabs_y = (diff_y > 13'sd0) ? -diff_y : diff_y;

    cmd.mode        = item.mode;
    cmd.x0          = item.start_x;
    cmd.y0          = item.start_y;
    cmd.x1          = item.end_x;
    cmd.y1          = item.end_y;
    cmd.delta_x     = abs_x;
    cmd.neg_delta_y = 14'(nabs_y);
    cmd.step_x_neg  = !(diff_x > 13'sd0);
    cmd.step_y_neg  = !(diff_y > 13'sd0);
    cmd.error_term  = 15'(abs_x) + 15'(nabs_y);
  end
endmodule

// File: hdl/lr_back.sv
`timescale 1ns / 1ps
module lr_back #(
  parameter int FRAME_WIDTH  = 800,
  parameter int FRAME_HEIGHT = 800
) (
  input  logic              clk,
  input  logic              rst,
  input  lr_pkg::cmd_t      cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic [31:0]       draw_color,
  output lr_pkg::out_item_t pix,
  output logic              pix_push,
  input  logic              pix_full
);
  import lr_pkg::*;

  localparam logic [10:0] FW = FRAME_WIDTH[10:0];
  localparam logic [10:0] FH = FRAME_HEIGHT[10:0];

  // line state
  logic signed [11:0] cur_x;
  logic signed [11:0] cur_y;
  logic signed [11:0] target_x;
  logic signed [11:0] target_y;
  logic [12:0]        delta_x;
  logic signed [13:0] neg_delta_y;
  logic               step_x_neg;
  logic               step_y_neg;
  logic signed [14:0] error_term;
  logic               line_active;

  // registered pixel stage
  logic               a_valid;
  logic signed [11:0] a_x;
  logic signed [11:0] a_y;
  logic               a_last;
  logic [31:0]        a_color;
  logic               a_ready;

  logic               is_start;
  logic               emit;
  logic signed [15:0] e2;
  logic               move_x;
  logic               move_y;
  logic signed [11:0] cur_x_next;
  logic signed [11:0] cur_y_next;
  logic signed [14:0] error_term_next;
  logic               last_next;

  logic               on;
  logic [19:0]        addr_full;

  assign a_ready  = !a_valid || !pix_full;
  assign cmd_pop  = !cmd_empty && a_ready;
  assign is_start = (cmd.mode == MODE_START);
  assign emit     = cmd_pop && (is_start || line_active);

  always_comb begin
    e2     = {error_term, 1'b0};
    move_x = (e2 >= 16'(neg_delta_y));
    move_y = (e2 <= $signed({3'b000, delta_x}));
    if (is_start) begin
      cur_x_next      = cmd.x0;
      cur_y_next      = cmd.y0;
      error_term_next = cmd.error_term;
      last_next       = (cmd.x0 == cmd.x1) && (cmd.y0 == cmd.y1);
    end else begin
      cur_x_next = cur_x;
      cur_y_next = cur_y;
      if (move_x) begin
        cur_x_next = step_x_neg ? cur_x - 12'sd1 : cur_x + 12'sd1;
      end
      if (move_y) begin
        cur_y_next = step_y_neg ? cur_y - 12'sd1 : cur_y + 12'sd1;
      end
      error_term_next = error_term
                      + (move_x ? 15'(neg_delta_y) : 15'sd0)
                      + (move_y ? $signed({2'b00, delta_x}) : 15'sd0);
      last_next = (cur_x_next == target_x) && (cur_y_next == target_y);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && is_start) begin
      target_x    <= cmd.x1;
      target_y    <= cmd.y1;
      delta_x     <= cmd.delta_x;
      neg_delta_y <= cmd.neg_delta_y;
      step_x_neg  <= cmd.step_x_neg;
      step_y_neg  <= cmd.step_y_neg;
    end
    if (emit) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      error_term <= error_term_next;
      a_x        <= cur_x_next;
      a_y        <= cur_y_next;
      a_last     <= last_next;
      a_color    <= draw_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      a_valid     <= 1'b0;
    end else begin
      if (emit) begin
        line_active <= !last_next;
      end
      if (a_ready) begin
        a_valid <= emit;
      end
    end
  end

  // bounds and linear address from the registered pixel
  always_comb begin
    on = !a_x[11] && (a_x[10:0] < FW) && !a_y[11] && (a_y[10:0] < FH);
    addr_full = 20'(a_y[10:0]) * 20'(FW) + 20'(a_x[10:0]);

    pix.pixel_x       = a_x;
    pix.pixel_y       = a_y;
    pix.on_screen     = on;
    pix.pixel_address = on ? addr_full : 20'd0;
    pix.pixel_color   = a_color;
    pix.last_pixel    = a_last;
  end

  assign pix_push = a_valid;
endmodule

// File: hdl/line_rasterizer.sv
`timescale 1ns / 1ps
// Bresenham line stepper, all octants.
// Request channel: push/full/item. mode START loads two endpoints and yields
// the first pixel; mode ADVANCE yields the next pixel of the active line, or
// nothing when no line is active (after the end point, or after reset).
// A START while a line is in progress abandons the old line.
// Result channel: empty/pop/result. The oldest pixel is on result while empty
// is low; pop takes it. Each pixel carries coordinates, an on-screen flag, the
// framebuffer address (0 when off screen), the draw color and a last flag.
// cfg_we/cfg_wdata write the draw color; write it only while the block is idle.
// A pixel passes the request queue, the registered pixel stage and the result
// queue. Throughput: one request per cycle unless the full result queue stalls
// the stepper; error/position update by adds and compares on registered state.
// When pop stalls, the 4-entry result queue fills, then the stepper and the
// 4-entry request queue hold, and full rises; nothing is dropped.
// Reset (rst, synchronous) empties both queues, ends any line and restores
// the draw color to 0x90FFFFC8.
module line_rasterizer #(
  parameter int FRAME_WIDTH  = 800,
  parameter int FRAME_HEIGHT = 800
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  lr_pkg::in_item_t  item,
  output logic              empty,
  input  logic              pop,
  output lr_pkg::out_item_t result,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);
  import lr_pkg::*;

  logic [31:0] draw_color;
  cmd_t        cmd_in;
  cmd_t        cmd_out;
  logic        cmd_empty;
  logic        cmd_pop;
  out_item_t   pix;
  logic        pix_push;
  logic        pix_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color <= COLOR_RESET;
    end else if (cfg_we) begin
      draw_color <= cfg_wdata;
    end
  end

  lr_front u_front (
    .item (item),
    .cmd  (cmd_in)
  );

  lr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (4)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  lr_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_out),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .draw_color (draw_color),
    .pix        (pix),
    .pix_push   (pix_push),
    .pix_full   (pix_full)
  );

  lr_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (4)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (pix_push),
    .wdata (pix),
    .full  (pix_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );
endmodule
